/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the sprite renderer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// Types, constants, pattern table and palette for the sprite pixel renderer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int SLOTS_DEF         = 64;
    localparam int SCREEN_WIDTH_DEF  = 224;
    localparam int SCREEN_HEIGHT_DEF = 256;
    localparam int SPRITE_SIZE       = 8;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic write;    // load one slot from the input item
        logic capture;  // latch query pixel, clear winner, rewind scan
        logic read;     // read the slot under the scan counter and advance
        logic finish;   // register the result and pulse the strobe
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_read;  // scan counter points at the last slot
    } ctrl_sts_t;

    // Stored attributes of one slot; the enable lives in flip-flops.
    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [2:0] pat;
        logic [5:0] hue;
    } attr_t;

    // One row of a fixed 8x8 pattern; leftmost column is bit 7.
    function automatic logic [7:0] shape_row(input logic [2:0] pat, input logic [2:0] row);
        logic [7:0] bits;
        bits = 8'h00;
        case (pat)
            3'd0: begin
                case (row)
                    3'd0: bits = 8'h24;  3'd1: bits = 8'h18;
                    3'd2: bits = 8'h3C;  3'd3: bits = 8'h5A;
                    3'd4: bits = 8'hFF;  3'd5: bits = 8'hBD;
                    3'd6: bits = 8'hA5;  default: bits = 8'h24;
                endcase
            end
            3'd1: begin
                case (row)
                    3'd0: bits = 8'h24;  3'd1: bits = 8'h99;
                    3'd2: bits = 8'hBD;  3'd3: bits = 8'hDB;
                    3'd4: bits = 8'h7E;  3'd5: bits = 8'h3C;
                    3'd6: bits = 8'h42;  default: bits = 8'h81;
                endcase
            end
            3'd2: begin
                case (row)
                    3'd0, 3'd1: bits = 8'h18;
                    3'd2, 3'd3: bits = 8'h3C;
                    3'd4, 3'd5: bits = 8'h7E;
                    default:    bits = 8'hFF;
                endcase
            end
            3'd3: bits = 8'h18;
            3'd4: bits = row[0] ? 8'h08 : 8'h10;
            3'd5: begin
                case (row)
                    3'd0, 3'd3, 3'd4, 3'd7: bits = 8'h42;
                    3'd1, 3'd6:             bits = 8'h24;
                    default:                bits = 8'h81;
                endcase
            end
            default: bits = 8'h00;  // blank patterns
        endcase
        return bits;
    endfunction

    function automatic logic [7:0] level_value(input logic [1:0] lvl);
        logic [7:0] v;
        case (lvl)
            2'd0:    v = 8'd0;
            2'd1:    v = 8'd85;
            2'd2:    v = 8'd170;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // Shade layout: green 5:4, red 3:2, blue 1:0.
    function automatic logic [31:0] shade_to_argb(input logic [5:0] shade);
        return {ALPHA_OPAQUE, level_value(shade[3:2]), level_value(shade[5:4]),
                level_value(shade[1:0])};
    endfunction

endpackage

/* design/sprite_pixel_renderer_core.sv */
// ----------------------------------------------------------------------------
// sprite_pixel_renderer_core
// Sprite engine: attribute table of 8x8 sprites, per-pixel color lookup.
// ----------------------------------------------------------------------------
//
//  channel   handshake             fields
//  -------   -------------------   --------------------------------------------
//  item in   start & !busy         op slot visible sprite_x sprite_y pattern
//                                  shade pixel_x pixel_y
//  result    done (1-cycle pulse)  argb covered
//
//  A write item leaves busy low and no result follows.
//  A query item scans every slot through one shared compare unit, one slot
//  per cycle: busy stays high through the scan and drain states and done
//  pulses in the cycle after busy falls.
//  The scan length is set by the single read port of the attribute memory.
//  Reset clears the per-slot enable flip-flops at once: no clearing pass.
//  The result is shown for one cycle only; the receiver cannot stall it.
//
module sprite_pixel_renderer_core #(
    parameter int SLOTS         = spr_pkg::SLOTS_DEF,
    parameter int SCREEN_WIDTH  = spr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = spr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [5:0]  slot,
    input  logic        visible,
    input  logic [7:0]  sprite_x,
    input  logic [7:0]  sprite_y,
    input  logic [2:0]  pattern,
    input  logic [5:0]  shade,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        done,
    output logic [31:0] argb,
    output logic        covered
);
    import spr_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequence writes and the slot scan.
    spr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the table, compare one slot per cycle, register the winner.
    spr_datapath #(
        .SLOTS         (SLOTS),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .slot     (slot),
        .visible  (visible),
        .sprite_x (sprite_x),
        .sprite_y (sprite_y),
        .pattern  (pattern),
        .shade    (shade),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .argb     (argb),
        .covered  (covered),
        .done     (done)
    );

endmodule

/* design/spr_ctrl.sv */
// ----------------------------------------------------------------------------
// spr_ctrl
// Controller: sequences slot writes and the per-slot scan of a pixel query.
// ----------------------------------------------------------------------------
module spr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               op,
    input  spr_pkg::ctrl_sts_t sts,
    output spr_pkg::ctrl_cmd_t cmd,
    output logic               busy
);
    import spr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (op == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_read)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.write   = start && (op == OP_WRITE);
                cmd.capture = start && (op == OP_QUERY);
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* design/spr_datapath.sv */
// ----------------------------------------------------------------------------
// spr_datapath
// Attribute memory, scan counter, shared hit compare and result registers.
// ----------------------------------------------------------------------------
module spr_datapath #(
    parameter int SLOTS         = spr_pkg::SLOTS_DEF,
    parameter int SCREEN_WIDTH  = spr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = spr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spr_pkg::ctrl_cmd_t cmd,
    output spr_pkg::ctrl_sts_t sts,
    input  logic [5:0]         slot,
    input  logic               visible,
    input  logic [7:0]         sprite_x,
    input  logic [7:0]         sprite_y,
    input  logic [2:0]         pattern,
    input  logic [5:0]         shade,
    input  logic [7:0]         pixel_x,
    input  logic [7:0]         pixel_y,
    output logic [31:0]        argb,
    output logic               covered,
    output logic               done
);
    import spr_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    attr_t               attr_mem [SLOTS];
    logic [SLOTS-1:0]    en_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic                rd_vld_reg;
    logic                rd_en_reg;
    attr_t               rd_attr_reg;
    logic [7:0]          px_reg;
    logic [7:0]          py_reg;
    logic                onscreen_reg;
    logic                hit_reg;
    logic                hit_next;
    logic [5:0]          hue_reg;
    logic [5:0]          hue_next;
    logic [31:0]         argb_reg;
    logic                covered_reg;
    logic                done_reg;

    logic [8:0]          slot_ext;
    logic [IDX_W-1:0]    wr_idx;
    logic                slot_ok;
    logic [8:0]          dx;
    logic [8:0]          dy;
    logic [7:0]          row_bits;
    logic                slot_hit;

    assign slot_ext = {3'b000, slot};
    assign wr_idx   = slot_ext[IDX_W-1:0];
    assign slot_ok  = slot_ext < 9'(SLOTS);

    // Attribute memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write && slot_ok)
        begin
            attr_mem[wr_idx] <= '{col: sprite_x, row: sprite_y, pat: pattern, hue: shade};
        end
        if (cmd.read)
        begin
            rd_attr_reg <= attr_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= '0;
            rd_vld_reg <= 1'b0;
            rd_en_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.write && slot_ok)
            begin
                en_reg[wr_idx] <= visible;
            end
            rd_vld_reg <= cmd.read;
            if (cmd.read)
            begin
                rd_en_reg <= en_reg[cnt_reg];
            end
            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.read)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign sts.last_read = (cnt_reg == IDX_W'(SLOTS - 1));

    // Shared compare: one slot per cycle against the latched pixel.
    assign dx       = {1'b0, px_reg} - {1'b0, rd_attr_reg.col};
    assign dy       = {1'b0, py_reg} - {1'b0, rd_attr_reg.row};
    assign row_bits = shape_row(rd_attr_reg.pat, dy[2:0]);
    assign slot_hit = rd_vld_reg && rd_en_reg && onscreen_reg
                   && (dx[8:3] == 6'd0) && (dy[8:3] == 6'd0)
                   && row_bits[3'd7 - dx[2:0]];

    // Later slots overwrite earlier ones: highest slot wins.
    always_comb
    begin
        hit_next = hit_reg;
        hue_next = hue_reg;
        if (slot_hit)
        begin
            hit_next = 1'b1;
            hue_next = rd_attr_reg.hue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg       <= pixel_x;
            py_reg       <= pixel_y;
            onscreen_reg <= ({1'b0, pixel_x} < 9'(SCREEN_WIDTH))
                         && ({1'b0, pixel_y} < 9'(SCREEN_HEIGHT));
            hit_reg      <= 1'b0;
            hue_reg      <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            hue_reg <= hue_next;
        end
        if (cmd.finish)
        begin
            covered_reg <= hit_next;
            argb_reg    <= hit_next ? shade_to_argb(hue_next) : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign argb    = argb_reg;
    assign covered = covered_reg;
    assign done    = done_reg;

endmodule

/* design/spr_checker.sv */
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks on the sprite renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        op,
    input logic        done,
    input logic [31:0] argb,
    input logic        covered
);
    import spr_pkg::*;

    `ASSERT_NEXT(a_query_goes_busy, clk, rst_n, start && !busy && (op == OP_QUERY), busy)
    `ASSERT_NEXT(a_single_pulse, clk, rst_n, done, !done)
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLIES(a_uncovered_black, clk, rst_n, done && !covered, argb == 32'd0)
    `ASSERT_IMPLIES(a_covered_opaque, clk, rst_n, done && covered, argb[31:24] == ALPHA_OPAQUE)

endmodule

bind sprite_pixel_renderer_core spr_checker u_spr_checker (.*);

/* dv/pixel_color_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_checker
// Watches the item and result channels of the sprite renderer, keeps its own
// copy of the sprite table, predicts the color of each queried pixel and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_color_checker
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        op,
    input  logic [5:0]  slot,
    input  logic        visible,
    input  logic [7:0]  sprite_x,
    input  logic [7:0]  sprite_y,
    input  logic [2:0]  pattern,
    input  logic [5:0]  shade,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic        done,
    input  logic [31:0] argb,
    input  logic        covered,
    output int          fail_count,
    output int          pending
);

    localparam int SLOT_COUNT = SLOTS_DEF;
    localparam int SCREEN_W   = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H   = SCREEN_HEIGHT_DEF;

    typedef struct packed {
        logic [31:0] argb;
        logic        covered;
    } pixel_t;

    typedef struct packed {
        logic       on;
        logic [7:0] col;
        logic [7:0] row;
        logic [2:0] pat;
        logic [5:0] hue;
    } slot_entry_t;

    slot_entry_t sprites [SLOT_COUNT];
    pixel_t      expected_pixels [$];

    // All eight rows of a pattern, top row in the high byte; blank codes give 0.
    function automatic logic [63:0] glyph(input logic [2:0] p);
        case (p)
            3'd0:    return 64'h2418_3C5A_FFBD_A524;
            3'd1:    return 64'h2499_BDDB_7E3C_4281;
            3'd2:    return 64'h1818_3C3C_7E7E_FFFF;
            3'd3:    return 64'h1818_1818_1818_1818;
            3'd4:    return 64'h1008_1008_1008_1008;
            3'd5:    return 64'h4224_8142_4281_2442;
            default: return 64'h0;
        endcase
    endfunction

    function automatic logic [7:0] tone(input logic [1:0] lvl);
        return 8'(lvl * 8'd85);
    endfunction

    // Scan every slot; the last enabled hit wins.
    function automatic pixel_t predict_pixel(input logic [7:0] px, input logic [7:0] py);
        pixel_t     r;
        int         dx;
        int         dy;
        logic [63:0] g;
        r = '0;
        if (px < SCREEN_W && py < SCREEN_H) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (sprites[i].on && px >= sprites[i].col && py >= sprites[i].row) begin
                    dx = px - sprites[i].col;
                    dy = py - sprites[i].row;
                    g  = glyph(sprites[i].pat);
                    if (dx < SPRITE_SIZE && dy < SPRITE_SIZE && g[63 - 8 * dy - dx]) begin
                        r.argb    = {ALPHA_OPAQUE, tone(sprites[i].hue[3:2]),
                                     tone(sprites[i].hue[5:4]), tone(sprites[i].hue[1:0])};
                        r.covered = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t pixel check: %s expected %h got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        pixel_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                sprites[i] = '0;
            expected_pixels.delete();
        end else begin
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    flag("unexpected result, argb", 32'h0, argb);
                end else begin
                    want = expected_pixels.pop_front();
                    if (argb !== want.argb)
                        flag("argb", want.argb, argb);
                    if (covered !== want.covered)
                        flag("covered", 32'(want.covered), 32'(covered));
                end
            end
            if (start && !busy) begin
                if (op == OP_WRITE) begin
                    if (slot < SLOT_COUNT) begin
                        sprites[slot].on  = visible;
                        sprites[slot].col = sprite_x;
                        sprites[slot].row = sprite_y;
                        sprites[slot].pat = pattern;
                        sprites[slot].hue = shade;
                    end
                end else begin
                    expected_pixels.push_back(predict_pixel(pixel_x, pixel_y));
                end
            end
        end
        pending <= expected_pixels.size();
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives write and query items into the sprite renderer: a directed opening
// on priority, blank patterns, disabling and edge clipping, then random
// sprites clustered around a moving focus with queries aimed at them. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    import spr_pkg::*;

    localparam int RANDOM_ITEMS = 880;
    // Quiet window: no gaps between items for this stretch of the random part.
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 550;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        op = OP_WRITE;
    logic [5:0]  slot = '0;
    logic        visible = 1'b0;
    logic [7:0]  sprite_x = '0;
    logic [7:0]  sprite_y = '0;
    logic [2:0]  pattern = '0;
    logic [5:0]  shade = '0;
    logic [7:0]  pixel_x = '0;
    logic [7:0]  pixel_y = '0;
    logic        done;
    logic [31:0] argb;
    logic        covered;

    int          mismatches;
    int          colors_pending;

    // Last position written to each slot; used only to aim queries.
    logic [7:0]  placed_x [SLOTS_DEF];
    logic [7:0]  placed_y [SLOTS_DEF];
    logic [7:0]  focus_x;
    logic [7:0]  focus_y;
    int          pick;
    int          k;

    // 4 ns period: two delays, high then low.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sprite_pixel_renderer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .slot     (slot),
        .visible  (visible),
        .sprite_x (sprite_x),
        .sprite_y (sprite_y),
        .pattern  (pattern),
        .shade    (shade),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .done     (done),
        .argb     (argb),
        .covered  (covered)
    );

    pixel_color_checker color_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .slot       (slot),
        .visible    (visible),
        .sprite_x   (sprite_x),
        .sprite_y   (sprite_y),
        .pattern    (pattern),
        .shade      (shade),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .done       (done),
        .argb       (argb),
        .covered    (covered),
        .fail_count (mismatches),
        .pending    (colors_pending)
    );

    // Present one item and hold it until an edge takes it with busy low.
    // Start is left high: the caller either presents the next item in the
    // same step or drops start in pause.
    task automatic issue(input logic o, input logic [5:0] s, input logic v,
                         input logic [7:0] x, input logic [7:0] y, input logic [2:0] p,
                         input logic [5:0] h, input logic [7:0] px, input logic [7:0] py);
        op       <= o;
        slot     <= s;
        visible  <= v;
        sprite_x <= x;
        sprite_y <= y;
        pattern  <= p;
        shade    <= h;
        pixel_x  <= px;
        pixel_y  <= py;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Idle the sender in about 9 of 100 slots. Most gaps are short; some are
    // long enough to land anywhere inside a query scan.
    task automatic pause(input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 9) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Load one slot; pixel fields carry junk since a write ignores them.
    task automatic write_sprite(input logic [5:0] s, input logic v, input logic [7:0] x,
                                input logic [7:0] y, input logic [2:0] p,
                                input logic [5:0] h, input bit quiet);
        issue(OP_WRITE, s, v, x, y, p, h, 8'($urandom), 8'($urandom));
        placed_x[s] = x;
        placed_y[s] = y;
        pause(quiet);
    endtask

    // Ask for one pixel; sprite fields carry junk since a query ignores them.
    task automatic query_pixel(input logic [7:0] px, input logic [7:0] py, input bit quiet);
        issue(OP_QUERY, 6'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
              3'($urandom), 6'($urandom), px, py);
        pause(quiet);
    endtask

    initial begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
            placed_x[i] = '0;
            placed_y[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opening ------------------------------------------------
        // Empty table: nothing covers the origin.
        query_pixel(8'd0, 8'd0, 1'b0);
        // Slot 0 at the origin, white; row 0 of the first pattern sets column 2.
        write_sprite(6'd0, 1'b1, 8'd0, 8'd0, 3'd0, 6'h3F, 1'b0);
        query_pixel(8'd2, 8'd0, 1'b0);
        query_pixel(8'd0, 8'd0, 1'b0);
        // Top slot on the same spot in black: it must win where both hit.
        write_sprite(6'd63, 1'b1, 8'd0, 8'd0, 3'd2, 6'h00, 1'b0);
        query_pixel(8'd3, 8'd0, 1'b0);
        query_pixel(8'd2, 8'd0, 1'b0);
        // Blank pattern in a middle slot draws nothing.
        write_sprite(6'd10, 1'b1, 8'd0, 8'd0, 3'd6, 6'h15, 1'b0);
        query_pixel(8'd5, 8'd0, 1'b0);
        // Turn the top slot blank too: the pixel it owned goes uncovered.
        write_sprite(6'd63, 1'b1, 8'd0, 8'd0, 3'd7, 6'h2A, 1'b0);
        query_pixel(8'd3, 8'd0, 1'b0);
        // Disable slot 0.
        write_sprite(6'd0, 1'b0, 8'd0, 8'd0, 3'd0, 6'h3F, 1'b0);
        query_pixel(8'd2, 8'd0, 1'b0);
        // Right edge: last visible column, then off screen.
        write_sprite(6'd5, 1'b1, 8'd220, 8'd100, 3'd2, 6'h2A, 1'b0);
        query_pixel(8'd223, 8'd106, 1'b0);
        query_pixel(8'd224, 8'd106, 1'b0);
        query_pixel(8'd255, 8'd255, 1'b0);
        // Sprite hanging past the right edge must not wrap to column 0.
        write_sprite(6'd6, 1'b1, 8'd250, 8'd200, 3'd2, 6'h11, 1'b0);
        query_pixel(8'd1, 8'd206, 1'b0);
        query_pixel(8'd1, 8'd207, 1'b0);
        // Bottom edge: last row hit, and no wrap to row 0.
        write_sprite(6'd7, 1'b1, 8'd50, 8'd252, 3'd3, 6'h3C, 1'b0);
        query_pixel(8'd53, 8'd255, 1'b0);
        query_pixel(8'd53, 8'd0, 1'b0);
        write_sprite(6'd8, 1'b1, 8'd255, 8'd255, 3'd4, 6'h03, 1'b0);
        query_pixel(8'd255, 8'd255, 1'b0);

        // ---- random part -----------------------------------------------------
        // Cluster sprites around a focus that moves now and then, so that
        // overlaps and priority come up often; aim most queries at a slot's
        // footprint plus a one-pixel fringe.
        focus_x = 8'($urandom_range(0, 210));
        focus_y = 8'($urandom_range(0, 240));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 4) begin
                focus_x = 8'($urandom_range(0, 255));
                focus_y = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 45) begin
                if (pick < 70)
                    write_sprite(6'($urandom), $urandom_range(0, 9) != 0,
                                 focus_x + 8'($urandom_range(0, 10)),
                                 focus_y + 8'($urandom_range(0, 10)),
                                 3'($urandom), 6'($urandom),
                                 n >= QUIET_FROM && n < QUIET_TO);
                else if (pick < 85)
                    write_sprite(6'($urandom), $urandom_range(0, 9) != 0,
                                 8'($urandom_range(212, 255)), 8'($urandom_range(244, 255)),
                                 3'($urandom), 6'($urandom),
                                 n >= QUIET_FROM && n < QUIET_TO);
                else
                    write_sprite(6'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                                 3'($urandom), 6'($urandom),
                                 n >= QUIET_FROM && n < QUIET_TO);
            end else begin
                k = $urandom_range(0, SLOTS_DEF - 1);
                if (pick < 75)
                    query_pixel(placed_x[k] + 8'($urandom_range(0, 9)) - 8'd1,
                                placed_y[k] + 8'($urandom_range(0, 9)) - 8'd1,
                                n >= QUIET_FROM && n < QUIET_TO);
                else if (pick < 88)
                    query_pixel(focus_x + 8'($urandom_range(0, 18)),
                                focus_y + 8'($urandom_range(0, 18)),
                                n >= QUIET_FROM && n < QUIET_TO);
                else
                    query_pixel(8'($urandom), 8'($urandom), n >= QUIET_FROM && n < QUIET_TO);
            end
        end

        // ---- drain and verdict ----------------------------------------------
        start <= 1'b0;
        while (colors_pending != 0)
            @(posedge clk);
        // A query scans every slot before its strobe; allow one full scan.
        repeat (SLOTS_DEF + 8) @(posedge clk);
        if (mismatches == 0 && colors_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop for a run that hangs; a correct run has roughly 900 items.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
